/* hw/rtl/tmr_pkg.sv */
// Shared types, constants and widths of the thruster mixer with ramp.
package tmr_pkg;

  // Lanes and number formats
  localparam int THRUSTER_COUNT       = 6;
  localparam int THRUST_FRACTION_BITS = 14;
  localparam int AXIS_COUNT           = 6;
  localparam int ROW_COUNT            = 6;
  localparam int OUT_THRUSTERS        = 6;
  localparam int AXIS_W               = 8;
  localparam int COEF_W               = 8;
  localparam int ROW_W                = AXIS_COUNT * COEF_W;
  localparam int BUTTON_W             = 10;
  localparam int SERVO_W              = 2;
  localparam int THRUST_W             = 16;
  localparam int ACCEL_W              = 15;
  localparam int LANE_W = (THRUSTER_COUNT > 1) ? $clog2(THRUSTER_COUNT) : 1;

  // Configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = ROW_W;
  localparam int ROW_IDX_W   = $clog2(ROW_COUNT);
  localparam logic [CFG_INDEX_W-1:0] CFG_ROW_LAST = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_ACCEL    = 3'd6;
  localparam logic [ACCEL_W-1:0]     ACCEL_RESET  = 15'd1638;

  // Axis positions inside an item
  localparam int AX_SURGE = 0;
  localparam int AX_SWAY  = 1;
  localparam int AX_HEAVE = 2;
  localparam int AX_PITCH = 3;
  localparam int AX_ROLL  = 4;
  localparam int AX_YAW   = 5;

  // Button bit positions
  localparam int BTN_HEAVE_UP   = 0;
  localparam int BTN_HEAVE_DOWN = 1;
  localparam int BTN_PITCH_UP   = 2;
  localparam int BTN_PITCH_DOWN = 3;
  localparam int BTN_ROLL_CW    = 4;
  localparam int BTN_ROLL_CCW   = 5;
  localparam int BTN_FRONT_CW   = 6;
  localparam int BTN_FRONT_CCW  = 7;
  localparam int BTN_BACK_CW    = 8;
  localparam int BTN_BACK_CCW   = 9;

  localparam logic signed [AXIS_W-1:0]  AXIS_FULL  = 8'sd100;
  localparam logic signed [SERVO_W-1:0] SERVO_CW   = 2'sb01;
  localparam logic signed [SERVO_W-1:0] SERVO_CCW  = 2'sb11;
  localparam logic signed [SERVO_W-1:0] SERVO_STOP = 2'sb00;

  // Internal thrust: Q2.F, holds +/-1.0
  localparam int TW = THRUST_FRACTION_BITS + 2;
  localparam logic signed [TW-1:0] THRUST_ONE = TW'(longint'(1) << THRUST_FRACTION_BITS);

  // Mixer: target = round(sum * 2^F / 6400), 6400 = 100 percent * Q1.6 scale.
  // Rewritten as (mag * 2^(F-8) + 12) / 25, with saturation above mag 6400.
  localparam int PROD_W        = AXIS_W + COEF_W;
  localparam int SUM_W         = PROD_W + $clog2(AXIS_COUNT);
  localparam int MIX_SAT       = 6400;
  localparam int SAT_W         = $clog2(MIX_SAT + 1);
  localparam int MIX_DIV       = 25;
  localparam int MIX_BIAS      = 12;
  localparam int MIX_PRE_SHIFT = THRUST_FRACTION_BITS - 8;
  localparam int NUM_W =
    $clog2((longint'(MIX_SAT) << MIX_PRE_SHIFT) + MIX_BIAS + 1);
  localparam int RECIP_SHIFT   = NUM_W + 5;
  localparam int RECIP_W       = RECIP_SHIFT - 4;
  localparam longint RECIP_VAL = (longint'(1) << RECIP_SHIFT) / MIX_DIV;
  localparam logic [RECIP_W-1:0] MIX_RECIP = RECIP_W'(RECIP_VAL);
  localparam int Q_W           = THRUST_FRACTION_BITS + 1;
  localparam logic [Q_W-1:0] Q_ONE = Q_W'(longint'(1) << THRUST_FRACTION_BITS);

  // Ramp: step = round(|diff| * accel / 2^F), signed back
  localparam int DIFF_W  = TW + 1;
  localparam int RMAG_W  = TW;
  localparam int CMP_W   = (RMAG_W > ACCEL_W) ? RMAG_W : ACCEL_W;
  localparam int RPROD_W = RMAG_W + ACCEL_W;
  localparam int STEP_W  = RPROD_W - THRUST_FRACTION_BITS + 2;
  localparam int NEXT_W  = ((STEP_W > TW) ? STEP_W : TW) + 1;
  localparam logic [RPROD_W:0] RAMP_HALF =
    (RPROD_W + 1)'(longint'(1) << (THRUST_FRACTION_BITS - 1));
  localparam logic signed [NEXT_W-1:0] NEXT_ONE = NEXT_W'(THRUST_ONE);

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    KIND_COMMAND = 1'b0,
    KIND_TICK    = 1'b1
  } item_kind_t;

  typedef struct packed {
    item_kind_t                         kind;
    logic [AXIS_COUNT-1:0][AXIS_W-1:0]  axis;
    logic signed [SERVO_W-1:0]          front_servo;
    logic signed [SERVO_W-1:0]          back_servo;
  } item_t;

endpackage

/* hw/rtl/tmr_front.sv */
// Front decode: applies button overrides and servo directions to an input item.
module tmr_front import tmr_pkg::*; (
  input  logic                     func,
  input  logic signed [AXIS_W-1:0] surge,
  input  logic signed [AXIS_W-1:0] sway,
  input  logic signed [AXIS_W-1:0] heave,
  input  logic signed [AXIS_W-1:0] pitch,
  input  logic signed [AXIS_W-1:0] roll,
  input  logic signed [AXIS_W-1:0] yaw,
  input  logic [BUTTON_W-1:0]      buttons,
  output item_t                    item
);

  // A held pair forces +/-100, both held gives zero
  function automatic logic signed [AXIS_W-1:0] pair_axis(logic up, logic down);
    logic signed [AXIS_W-1:0] v;
    v = '0;
    if (up && !down) v = AXIS_FULL;
    else if (down && !up) v = -AXIS_FULL;
    return v;
  endfunction

  function automatic logic signed [SERVO_W-1:0] servo_dir(logic cw, logic ccw);
    logic signed [SERVO_W-1:0] v;
    v = SERVO_STOP;
    if (cw && !ccw) v = SERVO_CW;
    else if (ccw && !cw) v = SERVO_CCW;
    return v;
  endfunction

  // Classify and build the queued item
  always_comb begin
    item.kind = func ? KIND_TICK : KIND_COMMAND;
    item.axis[AX_SURGE] = surge;
    item.axis[AX_SWAY]  = sway;
    item.axis[AX_YAW]   = yaw;
    if (buttons[BTN_HEAVE_UP] || buttons[BTN_HEAVE_DOWN]) begin
      item.axis[AX_HEAVE] = pair_axis(buttons[BTN_HEAVE_UP], buttons[BTN_HEAVE_DOWN]);
    end else begin
      item.axis[AX_HEAVE] = heave;
    end
    if (buttons[BTN_PITCH_UP] || buttons[BTN_PITCH_DOWN]) begin
      item.axis[AX_PITCH] = pair_axis(buttons[BTN_PITCH_UP], buttons[BTN_PITCH_DOWN]);
    end else begin
      item.axis[AX_PITCH] = pitch;
    end
    if (buttons[BTN_ROLL_CW] || buttons[BTN_ROLL_CCW]) begin
      item.axis[AX_ROLL] = pair_axis(buttons[BTN_ROLL_CW], buttons[BTN_ROLL_CCW]);
    end else begin
      item.axis[AX_ROLL] = roll;
    end
    item.front_servo = servo_dir(buttons[BTN_FRONT_CW], buttons[BTN_FRONT_CCW]);
    item.back_servo  = servo_dir(buttons[BTN_BACK_CW], buttons[BTN_BACK_CCW]);
  end

endmodule

/* hw/rtl/tmr_queue.sv */
// Short item queue between the front decode and the back execution.
module tmr_queue import tmr_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  not_empty,
  output item_t head
);

  item_t             entry [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full      = (count == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = entry[rd_ptr];

  // Store pushed items
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_item;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

/* hw/rtl/tmr_back.sv */
// Back execution: lane sequencer, mixer pipeline, ramp pipeline and result register.
module tmr_back import tmr_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write_en,
  input  logic [CFG_INDEX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  input  logic                       item_valid,
  input  item_t                      item,
  output logic                       item_pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [THRUST_W-1:0] thrust [OUT_THRUSTERS],
  output logic signed [SERVO_W-1:0]  front_servo,
  output logic signed [SERVO_W-1:0]  back_servo
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_ISSUE = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  // Configuration registers
  logic [ROW_W-1:0]   coef_row [ROW_COUNT];
  logic [ACCEL_W-1:0] accel;

  // Block state
  logic signed [TW-1:0]      target  [THRUSTER_COUNT];
  logic signed [TW-1:0]      current [THRUSTER_COUNT];
  logic signed [SERVO_W-1:0] servo_front;
  logic signed [SERVO_W-1:0] servo_back;

  // Sequencer
  state_t                            state;
  state_t                            state_next;
  logic [LANE_W-1:0]                 lane;
  item_kind_t                        cur_kind;
  logic [AXIS_COUNT-1:0][AXIS_W-1:0] axis_reg;
  logic                              start_ok;
  logic                              pipe_busy;
  logic                              issue;
  logic                              lane_last;

  // Mixer pipeline
  logic                     m1_valid;
  logic [LANE_W-1:0]        m1_lane;
  logic signed [PROD_W-1:0] m1_prod [AXIS_COUNT];
  logic                     m2_valid;
  logic [LANE_W-1:0]        m2_lane;
  logic [NUM_W-1:0]         m2_num;
  logic                     m2_neg;
  logic                     m2_over;
  logic                     m3_valid;
  logic [LANE_W-1:0]        m3_lane;
  logic [NUM_W-1:0]         m3_num;
  logic [Q_W-1:0]           m3_q;
  logic                     m3_neg;
  logic                     m3_over;

  // Ramp pipeline
  logic                 r1_valid;
  logic                 r1_last;
  logic [LANE_W-1:0]    r1_lane;
  logic [RMAG_W-1:0]    r1_mag;
  logic                 r1_neg;
  logic                 r1_big;
  logic signed [TW-1:0] r1_target;
  logic signed [TW-1:0] r1_cur;
  logic                 r2_valid;
  logic                 r2_last;
  logic [LANE_W-1:0]    r2_lane;
  logic [RPROD_W-1:0]   r2_prod;
  logic                 r2_neg;
  logic                 r2_big;
  logic signed [TW-1:0] r2_target;
  logic signed [TW-1:0] r2_cur;

  // Result register
  logic signed [TW-1:0]      out_thrust [THRUSTER_COUNT];
  logic signed [SERVO_W-1:0] out_front;
  logic signed [SERVO_W-1:0] out_back;

  // Stage comb values
  logic [ROW_W-1:0]            row_sel;
  logic signed [PROD_W-1:0]    prod_next [AXIS_COUNT];
  logic signed [SUM_W-1:0]     mix_sum;
  logic [SUM_W-1:0]            mix_mag;
  logic [NUM_W-1:0]            mix_num;
  logic [NUM_W+RECIP_W-1:0]    recip_prod;
  logic [NUM_W-1:0]            q25;
  logic [NUM_W-1:0]            rem;
  logic [Q_W-1:0]              q_fix;
  logic [Q_W-1:0]              tmag;
  logic signed [TW-1:0]        tpos;
  logic signed [TW-1:0]        target_new;
  logic signed [DIFF_W-1:0]    diff;
  logic signed [DIFF_W-1:0]    dabs;
  logic [RPROD_W:0]            rounded;
  logic signed [STEP_W-1:0]    step_pos;
  logic signed [STEP_W-1:0]    step;
  logic signed [NEXT_W-1:0]    sum_next;
  logic signed [TW-1:0]        clamped;
  logic signed [TW-1:0]        ramp_new;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < ROW_COUNT; r++) coef_row[r] <= '0;
      accel <= ACCEL_RESET;
    end else if (cfg_write_en) begin
      if (cfg_index <= CFG_ROW_LAST) begin
        coef_row[ROW_IDX_W'(cfg_index)] <= cfg_data[ROW_W-1:0];
      end else if (cfg_index == CFG_ACCEL) begin
        accel <= cfg_data[ACCEL_W-1:0];
      end
    end
  end

  // Sequencer control: a tick waits for a free result register
  assign pipe_busy = m1_valid | m2_valid | r1_valid;
  assign start_ok  = item_valid &&
                     (item.kind == KIND_COMMAND || (!out_valid && !r2_valid));
  assign issue     = (state == ST_ISSUE);
  assign lane_last = (lane == LANE_W'(THRUSTER_COUNT - 1));

  always_comb begin
    state_next = state;
    item_pop   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (start_ok) begin
          item_pop   = 1'b1;
          state_next = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (lane_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!pipe_busy) begin
          if (start_ok) begin
            item_pop   = 1'b1;
            state_next = ST_ISSUE;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      lane        <= '0;
      cur_kind    <= KIND_COMMAND;
      servo_front <= SERVO_STOP;
      servo_back  <= SERVO_STOP;
    end else begin
      state <= state_next;
      if (item_pop) begin
        lane     <= '0;
        cur_kind <= item.kind;
        if (item.kind == KIND_COMMAND) begin
          servo_front <= item.front_servo;
          servo_back  <= item.back_servo;
        end
      end else if (issue && !lane_last) begin
        lane <= lane + 1'b1;
      end
    end
  end

  // Hold the axes of the item in work
  always_ff @(posedge clk) begin
    if (item_pop) axis_reg <= item.axis;
  end

  // Mixer stage 0: six axis by coefficient products
  always_comb begin
    row_sel = '0;
    if (lane < ROW_COUNT) row_sel = coef_row[ROW_IDX_W'(lane)];
    for (int k = 0; k < AXIS_COUNT; k++) begin
      prod_next[k] = $signed(axis_reg[k]) * $signed(row_sel[k*COEF_W +: COEF_W]);
    end
  end

  // Mixer stage 1: sum, magnitude and scaled numerator
  always_comb begin
    mix_sum = '0;
    for (int k = 0; k < AXIS_COUNT; k++) mix_sum = mix_sum + SUM_W'(m1_prod[k]);
    mix_mag = mix_sum[SUM_W-1] ? SUM_W'(-mix_sum) : SUM_W'(mix_sum);
    mix_num = (NUM_W'(mix_mag[SAT_W-1:0]) << MIX_PRE_SHIFT) + NUM_W'(MIX_BIAS);
  end

  // Mixer stage 2: divide by 25 through the reciprocal
  assign recip_prod = (NUM_W + RECIP_W)'(m2_num) * (NUM_W + RECIP_W)'(MIX_RECIP);

  // Mixer stage 3: correct the estimate, saturate and restore the sign
  always_comb begin
    q25        = NUM_W'(m3_q) * NUM_W'(MIX_DIV);
    rem        = m3_num - q25;
    q_fix      = (rem >= NUM_W'(MIX_DIV)) ? m3_q + 1'b1 : m3_q;
    tmag       = m3_over ? Q_ONE : q_fix;
    tpos       = signed'({1'b0, tmag});
    target_new = m3_neg ? -tpos : tpos;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
      m2_valid <= 1'b0;
      m3_valid <= 1'b0;
    end else begin
      m1_valid <= issue && (cur_kind == KIND_COMMAND);
      m2_valid <= m1_valid;
      m3_valid <= m2_valid;
    end
  end

  always_ff @(posedge clk) begin
    m1_lane <= lane;
    for (int k = 0; k < AXIS_COUNT; k++) m1_prod[k] <= prod_next[k];
    m2_lane <= m1_lane;
    m2_num  <= mix_num;
    m2_neg  <= mix_sum[SUM_W-1];
    m2_over <= (mix_mag > SUM_W'(MIX_SAT));
    m3_lane <= m2_lane;
    m3_num  <= m2_num;
    m3_q    <= recip_prod[RECIP_SHIFT +: Q_W];
    m3_neg  <= m2_neg;
    m3_over <= m2_over;
  end

  // Ramp stage 0: difference to target and threshold compare
  always_comb begin
    diff = DIFF_W'(target[lane]) - DIFF_W'(current[lane]);
    dabs = diff[DIFF_W-1] ? -diff : diff;
  end

  // Ramp stage 2: round the step, add and saturate
  always_comb begin
    rounded  = (RPROD_W + 1)'(r2_prod) + RAMP_HALF;
    step_pos = signed'({1'b0, rounded[RPROD_W:THRUST_FRACTION_BITS]});
    step     = r2_neg ? -step_pos : step_pos;
    sum_next = NEXT_W'(r2_cur) + NEXT_W'(step);
    if (sum_next > NEXT_ONE) clamped = THRUST_ONE;
    else if (sum_next < -NEXT_ONE) clamped = -THRUST_ONE;
    else clamped = TW'(sum_next);
    ramp_new = r2_big ? clamped : r2_target;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r1_valid <= 1'b0;
      r2_valid <= 1'b0;
    end else begin
      r1_valid <= issue && (cur_kind == KIND_TICK);
      r2_valid <= r1_valid;
    end
  end

  always_ff @(posedge clk) begin
    r1_last   <= lane_last;
    r1_lane   <= lane;
    r1_mag    <= dabs[RMAG_W-1:0];
    r1_neg    <= diff[DIFF_W-1];
    r1_big    <= (CMP_W'(dabs[RMAG_W-1:0]) > CMP_W'(accel));
    r1_target <= target[lane];
    r1_cur    <= current[lane];
    r2_last   <= r1_last;
    r2_lane   <= r1_lane;
    r2_prod   <= RPROD_W'(r1_mag) * RPROD_W'(accel);
    r2_neg    <= r1_neg;
    r2_big    <= r1_big;
    r2_target <= r1_target;
    r2_cur    <= r1_cur;
  end

  // Write targets and current thrusts
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < THRUSTER_COUNT; i++) begin
        target[i]  <= '0;
        current[i] <= '0;
      end
    end else begin
      if (m3_valid) target[m3_lane] <= target_new;
      if (r2_valid) current[r2_lane] <= ramp_new;
    end
  end

  // Result register: filled lane by lane during a tick
  always_ff @(posedge clk) begin
    if (r2_valid) out_thrust[r2_lane] <= ramp_new;
    if (item_pop && item.kind == KIND_TICK) begin
      out_front <= servo_front;
      out_back  <= servo_back;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (r2_valid && r2_last) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Drive result fields, absent thrusters read zero
  for (genvar i = 0; i < OUT_THRUSTERS; i++) begin : g_out
    if (i < THRUSTER_COUNT) begin : g_lane
      assign thrust[i] = THRUST_W'(out_thrust[i]);
    end else begin : g_zero
      assign thrust[i] = '0;
    end
  end

  assign front_servo = out_front;
  assign back_servo  = out_back;

endmodule

/* hw/rtl/thruster_mixer_with_ramp_unit.sv */
// Top level of the thruster mixer with ramp: front decode, item queue and back execution.
//
//   channel   direction  handshake               payload
//   config    in         cfg_write_en            cfg_index, cfg_data
//   command   in         in_valid / in_stall     func, surge..yaw, buttons
//   result    out        out_valid / out_stall   thrust_0..thrust_5, front_servo, back_servo
//
// The back runs one lane per cycle through a 4-stage mixer or a 3-stage ramp pipeline,
// one lane per thruster; a tick does not start until the result register has been taken.
// A two-entry queue keeps accepting items, until it is full, while the back works or the result is stalled.
// rst is synchronous and clears the queue, sequencer, rows, targets and ramp state; acceleration returns to 1638.
module thruster_mixer_with_ramp_unit import tmr_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write_en,
  input  logic [CFG_INDEX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       func,
  input  logic signed [AXIS_W-1:0]   surge,
  input  logic signed [AXIS_W-1:0]   sway,
  input  logic signed [AXIS_W-1:0]   heave,
  input  logic signed [AXIS_W-1:0]   pitch,
  input  logic signed [AXIS_W-1:0]   roll,
  input  logic signed [AXIS_W-1:0]   yaw,
  input  logic [BUTTON_W-1:0]        buttons,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [THRUST_W-1:0] thrust_0,
  output logic signed [THRUST_W-1:0] thrust_1,
  output logic signed [THRUST_W-1:0] thrust_2,
  output logic signed [THRUST_W-1:0] thrust_3,
  output logic signed [THRUST_W-1:0] thrust_4,
  output logic signed [THRUST_W-1:0] thrust_5,
  output logic signed [SERVO_W-1:0]  front_servo,
  output logic signed [SERVO_W-1:0]  back_servo
);

  item_t                      front_item;
  item_t                      head_item;
  logic                       queue_full;
  logic                       queue_ready;
  logic                       pop;
  logic signed [THRUST_W-1:0] thrust [OUT_THRUSTERS];

  // Accept a transaction when the queue has room
  assign in_stall = queue_full;

  tmr_front u_front (
    .func    (func),
    .surge   (surge),
    .sway    (sway),
    .heave   (heave),
    .pitch   (pitch),
    .roll    (roll),
    .yaw     (yaw),
    .buttons (buttons),
    .item    (front_item)
  );

  tmr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_valid && !queue_full),
    .push_item (front_item),
    .full      (queue_full),
    .pop       (pop),
    .not_empty (queue_ready),
    .head      (head_item)
  );

  tmr_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (queue_ready),
    .item         (head_item),
    .item_pop     (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .thrust       (thrust),
    .front_servo  (front_servo),
    .back_servo   (back_servo)
  );

  assign thrust_0 = thrust[0];
  assign thrust_1 = thrust[1];
  assign thrust_2 = thrust[2];
  assign thrust_3 = thrust[3];
  assign thrust_4 = thrust[4];
  assign thrust_5 = thrust[5];

endmodule

/* hw/rtl/tmr_checker.sv */
// Port-level checks of the thruster mixer with ramp, bound to the top level.
module tmr_checker import tmr_pkg::*; (
  input logic                       clk,
  input logic                       rst,
  input logic                       cfg_write_en,
  input logic [CFG_INDEX_W-1:0]     cfg_index,
  input logic [CFG_DATA_W-1:0]      cfg_data,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       func,
  input logic signed [AXIS_W-1:0]   surge,
  input logic signed [AXIS_W-1:0]   sway,
  input logic signed [AXIS_W-1:0]   heave,
  input logic signed [AXIS_W-1:0]   pitch,
  input logic signed [AXIS_W-1:0]   roll,
  input logic signed [AXIS_W-1:0]   yaw,
  input logic [BUTTON_W-1:0]        buttons,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic signed [THRUST_W-1:0] thrust_0,
  input logic signed [THRUST_W-1:0] thrust_1,
  input logic signed [THRUST_W-1:0] thrust_2,
  input logic signed [THRUST_W-1:0] thrust_3,
  input logic signed [THRUST_W-1:0] thrust_4,
  input logic signed [THRUST_W-1:0] thrust_5,
  input logic signed [SERVO_W-1:0]  front_servo,
  input logic signed [SERVO_W-1:0]  back_servo
);

  localparam int OUT_LIMIT = (TW <= THRUST_W) ? (1 << THRUST_FRACTION_BITS)
                                              : ((1 << (THRUST_W - 1)) - 1);

  // Reset empties the queue and drops any pending result
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid && !in_stall)
    else $error("result or stall present after reset");

  // A stalled result holds its transaction
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(thrust_0) && $stable(thrust_5) &&
      $stable(front_servo) && $stable(back_servo))
    else $error("stalled result changed");

  // Servo directions are only -1, 0 or +1
  a_servo_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> front_servo != 2'b10 && back_servo != 2'b10)
    else $error("servo direction out of range");

  // Ramped thrust stays within +/-1.0
  a_thrust_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> int'(thrust_0) <= OUT_LIMIT && int'(thrust_0) >= -OUT_LIMIT &&
      int'(thrust_5) <= OUT_LIMIT && int'(thrust_5) >= -OUT_LIMIT)
    else $error("thrust beyond full scale");

endmodule

bind thruster_mixer_with_ramp_unit tmr_checker u_tmr_checker (.*);

/* sim/thruster_mixer_with_ramp_unit_checker.sv */
// Checker for the thruster mixer: tracks transactions, predicts results and compares them.
`timescale 1ns / 100ps
module thruster_mixer_with_ramp_unit_checker import tmr_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write_en,
  input  logic [CFG_INDEX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic                       func,
  input  logic signed [AXIS_W-1:0]   surge,
  input  logic signed [AXIS_W-1:0]   sway,
  input  logic signed [AXIS_W-1:0]   heave,
  input  logic signed [AXIS_W-1:0]   pitch,
  input  logic signed [AXIS_W-1:0]   roll,
  input  logic signed [AXIS_W-1:0]   yaw,
  input  logic [BUTTON_W-1:0]        buttons,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic signed [THRUST_W-1:0] thrust_0,
  input  logic signed [THRUST_W-1:0] thrust_1,
  input  logic signed [THRUST_W-1:0] thrust_2,
  input  logic signed [THRUST_W-1:0] thrust_3,
  input  logic signed [THRUST_W-1:0] thrust_4,
  input  logic signed [THRUST_W-1:0] thrust_5,
  input  logic signed [SERVO_W-1:0]  front_servo,
  input  logic signed [SERVO_W-1:0]  back_servo,
  output int                         fail_count,
  output int                         pending
);

  // 1.0 in thrust units, and 100 percent times the Q1.6 coefficient scale
  localparam longint THRUST_SCALE = longint'(1) << THRUST_FRACTION_BITS;
  localparam longint MIX_SCALE    = 100 * 64;
  localparam int     REPORT_LINES = 40;

  typedef struct packed {
    logic [OUT_THRUSTERS-1:0][THRUST_W-1:0] thrust;
    logic [SERVO_W-1:0]                     front;
    logic [SERVO_W-1:0]                     back;
  } thrust_report_t;

  // Predicted block state
  logic [ROW_W-1:0]   coef_row [ROW_COUNT];
  logic [ACCEL_W-1:0] accel;
  longint             target [OUT_THRUSTERS];
  longint             current [OUT_THRUSTERS];
  int                 servo_front;
  int                 servo_back;
  thrust_report_t     ramp_reports [$];

  function automatic longint div_nearest(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic longint clamp_one(longint v);
    if (v > THRUST_SCALE) return THRUST_SCALE;
    if (v < -THRUST_SCALE) return -THRUST_SCALE;
    return v;
  endfunction

  // First button of a pair counts +1, second -1
  function automatic int pair_dir(logic [BUTTON_W-1:0] b, int lo);
    return int'(b[lo]) - int'(b[lo + 1]);
  endfunction

  // Mix a pilot command into new targets and servo directions
  function automatic void mix_command();
    int     axis [AXIS_COUNT];
    longint sum;
    axis[AX_SURGE] = int'(surge);
    axis[AX_SWAY]  = int'(sway);
    axis[AX_HEAVE] = int'(heave);
    axis[AX_PITCH] = int'(pitch);
    axis[AX_ROLL]  = int'(roll);
    axis[AX_YAW]   = int'(yaw);
    if (buttons[BTN_HEAVE_UP] || buttons[BTN_HEAVE_DOWN])
      axis[AX_HEAVE] = pair_dir(buttons, BTN_HEAVE_UP) * int'(AXIS_FULL);
    if (buttons[BTN_PITCH_UP] || buttons[BTN_PITCH_DOWN])
      axis[AX_PITCH] = pair_dir(buttons, BTN_PITCH_UP) * int'(AXIS_FULL);
    if (buttons[BTN_ROLL_CW] || buttons[BTN_ROLL_CCW])
      axis[AX_ROLL] = pair_dir(buttons, BTN_ROLL_CW) * int'(AXIS_FULL);
    for (int i = 0; i < OUT_THRUSTERS; i++) begin
      sum = 0;
      if (i < ROW_COUNT) begin
        for (int k = 0; k < AXIS_COUNT; k++)
          sum += longint'(axis[k]) * longint'($signed(coef_row[i][COEF_W*k +: COEF_W]));
      end
      target[i] = clamp_one(div_nearest(sum * THRUST_SCALE, MIX_SCALE));
    end
    servo_front = pair_dir(buttons, BTN_FRONT_CW);
    servo_back  = pair_dir(buttons, BTN_BACK_CW);
  endfunction

  // Ramp every lane one tick toward its target and build the result
  function automatic thrust_report_t ramp_tick();
    thrust_report_t rep;
    longint         diff;
    longint         mag;
    for (int i = 0; i < OUT_THRUSTERS; i++) begin
      diff = target[i] - current[i];
      mag = (diff < 0) ? -diff : diff;
      if (mag > longint'(accel))
        current[i] = clamp_one(current[i] + div_nearest(diff * longint'(accel), THRUST_SCALE));
      else
        current[i] = target[i];
      rep.thrust[i] = (i < THRUSTER_COUNT) ? THRUST_W'(current[i]) : '0;
    end
    rep.front = SERVO_W'(servo_front);
    rep.back  = SERVO_W'(servo_back);
    return rep;
  endfunction

  task automatic report_mismatch(input string what);
    if (fail_count < REPORT_LINES)
      $display("%0t ns mismatch: %s", $time, what);
    fail_count++;
  endtask

  // Watch the channels on each rising edge
  always @(posedge clk) begin
    thrust_report_t got;
    thrust_report_t want;
    if (rst) begin
      for (int r = 0; r < ROW_COUNT; r++) coef_row[r] = '0;
      accel = ACCEL_RESET;
      for (int i = 0; i < OUT_THRUSTERS; i++) begin
        target[i] = 0;
        current[i] = 0;
      end
      servo_front = 0;
      servo_back = 0;
      ramp_reports.delete();
    end else begin
      // Register writes; indexes past the acceleration register are ignored
      if (cfg_write_en) begin
        if (cfg_index <= CFG_ROW_LAST)
          coef_row[cfg_index] = cfg_data;
        else if (cfg_index == CFG_ACCEL)
          accel = cfg_data[ACCEL_W-1:0];
      end
      // Compare an accepted result with the oldest prediction
      if (out_valid && !out_stall) begin
        got = '{thrust: {thrust_5, thrust_4, thrust_3, thrust_2, thrust_1, thrust_0},
                front: front_servo, back: back_servo};
        if (ramp_reports.size() == 0) begin
          report_mismatch("result transaction with no prediction waiting");
        end else begin
          want = ramp_reports.pop_front();
          for (int i = 0; i < OUT_THRUSTERS; i++) begin
            if (got.thrust[i] !== want.thrust[i])
              report_mismatch($sformatf("thrust_%0d got %0d want %0d", i,
                              $signed(got.thrust[i]), $signed(want.thrust[i])));
          end
          if (got.front !== want.front)
            report_mismatch($sformatf("front_servo got %0d want %0d",
                            $signed(got.front), $signed(want.front)));
          if (got.back !== want.back)
            report_mismatch($sformatf("back_servo got %0d want %0d",
                            $signed(got.back), $signed(want.back)));
        end
      end
      // Advance the prediction on an accepted input transaction
      if (in_valid && !in_stall) begin
        if (func == KIND_TICK)
          ramp_reports.push_back(ramp_tick());
        else
          mix_command();
      end
    end
    pending = ramp_reports.size();
  end

endmodule

/* sim/thruster_mixer_with_ramp_unit_tb.sv */
// Testbench top: drives commands, ticks and register writes into the thruster mixer.
`timescale 1ns / 100ps
module thruster_mixer_with_ramp_unit_tb;
  import tmr_pkg::*;

  localparam int HALF_HIGH    = 6;
  localparam int HALF_LOW     = 6;
  localparam int RESET_CYCLES = 9;
  localparam int QUIET_CYCLES = 40;
  // Bound on a run of every item with its gaps, block time and stalls
  localparam int CYCLE_LIMIT  = 600000;
  localparam int PHASE_COUNT  = 7;
  localparam int PHASE_ITEMS  = 100;
  localparam logic [CFG_INDEX_W-1:0] CFG_ROW_FIRST = '0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE     = CFG_ACCEL + 1'b1;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_CADENCE,
    STALL_RANDOM,
    STALL_HOLD
  } stall_mode_t;

  typedef struct packed {
    item_kind_t                        kind;
    logic [AXIS_COUNT-1:0][AXIS_W-1:0] axis;
    logic [BUTTON_W-1:0]               buttons;
  } pilot_item_t;

  logic                       clk;
  logic                       rst = 1'b1;
  logic                       cfg_write_en = 1'b0;
  logic [CFG_INDEX_W-1:0]     cfg_index = '0;
  logic [CFG_DATA_W-1:0]      cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic                       func = 1'b0;
  logic signed [AXIS_W-1:0]   surge = '0;
  logic signed [AXIS_W-1:0]   sway = '0;
  logic signed [AXIS_W-1:0]   heave = '0;
  logic signed [AXIS_W-1:0]   pitch = '0;
  logic signed [AXIS_W-1:0]   roll = '0;
  logic signed [AXIS_W-1:0]   yaw = '0;
  logic [BUTTON_W-1:0]        buttons = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [THRUST_W-1:0] thrust_0;
  logic signed [THRUST_W-1:0] thrust_1;
  logic signed [THRUST_W-1:0] thrust_2;
  logic signed [THRUST_W-1:0] thrust_3;
  logic signed [THRUST_W-1:0] thrust_4;
  logic signed [THRUST_W-1:0] thrust_5;
  logic signed [SERVO_W-1:0]  front_servo;
  logic signed [SERVO_W-1:0]  back_servo;

  int          fail_count;
  int          pending;
  int          cycle_count = 0;
  int          burst_left = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_mode_left = 0;
  int          stall_hold = 0;

  thruster_mixer_with_ramp_unit dut (.*);

  thruster_mixer_with_ramp_unit_checker thrust_check (.*);

  always begin
    clk = 1'b0;
    #HALF_LOW;
    clk = 1'b1;
    #HALF_HIGH;
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL thruster_mixer_with_ramp_unit");
      $finish;
    end
  end

  // Result side stalls on its own pattern, switching modes now and then
  always @(negedge clk) begin
    if (stall_mode_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_mode_left = $urandom_range(40, 400);
    end else begin
      stall_mode_left--;
    end
    case (stall_mode)
      STALL_NONE: begin
        out_stall <= 1'b0;
      end
      STALL_CADENCE: begin
        out_stall <= (stall_mode_left % 3) == 0;
      end
      STALL_RANDOM: begin
        out_stall <= 1'($urandom_range(0, 1));
      end
      default: begin
        if (stall_hold > 0)
          stall_hold--;
        else if ($urandom_range(0, 7) == 0)
          stall_hold = $urandom_range(5, 25);
        out_stall <= stall_hold > 0;
      end
    endcase
  end

  function automatic logic [AXIS_W-1:0] random_axis();
    case ($urandom_range(0, 9))
      0, 1:    return AXIS_W'(int'($urandom_range(0, 2)) * 100 - 100);
      2:       return AXIS_W'($urandom_range(0, 255));
      default: return AXIS_W'(int'($urandom_range(0, 200)) - 100);
    endcase
  endfunction

  function automatic pilot_item_t command_of(int s, int sw, int h, int p, int r, int y,
                                             int b);
    pilot_item_t it;
    it.kind = KIND_COMMAND;
    it.axis[AX_SURGE] = AXIS_W'(s);
    it.axis[AX_SWAY]  = AXIS_W'(sw);
    it.axis[AX_HEAVE] = AXIS_W'(h);
    it.axis[AX_PITCH] = AXIS_W'(p);
    it.axis[AX_ROLL]  = AXIS_W'(r);
    it.axis[AX_YAW]   = AXIS_W'(y);
    it.buttons = BUTTON_W'(b);
    return it;
  endfunction

  // Random command; buttons are often idle
  function automatic pilot_item_t random_command();
    pilot_item_t it;
    it.kind = KIND_COMMAND;
    for (int k = 0; k < AXIS_COUNT; k++) it.axis[k] = random_axis();
    it.buttons = ($urandom_range(0, 1) == 0) ? '0 : BUTTON_W'($urandom_range(0, 1023));
    return it;
  endfunction

  // Tick with junk in the fields it does not use
  function automatic pilot_item_t tick_of();
    pilot_item_t it;
    it = random_command();
    it.kind = KIND_TICK;
    return it;
  endfunction

  // Coefficient row: full bytes or values within +/-1.0
  function automatic logic [ROW_W-1:0] random_row(bit full_range);
    logic [ROW_W-1:0] row;
    for (int k = 0; k < AXIS_COUNT; k++) begin
      if (full_range)
        row[COEF_W*k +: COEF_W] = COEF_W'($urandom_range(0, 255));
      else
        row[COEF_W*k +: COEF_W] = COEF_W'(int'($urandom_range(0, 128)) - 64);
    end
    return row;
  endfunction

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_write_en = 1'b1;
    cfg_index = index;
    cfg_data = data;
    @(negedge clk);
    cfg_write_en = 1'b0;
  endtask

  task automatic idle(input int cycles);
    in_valid = 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // Bursts of random length with random gaps between them
  task automatic pace();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) idle($urandom_range(1, 10));
    end
    burst_left--;
  endtask

  // Present one transaction and hold it until taken
  task automatic send_item(input pilot_item_t it);
    pace();
    in_valid = 1'b1;
    func = it.kind;
    surge = it.axis[AX_SURGE];
    sway = it.axis[AX_SWAY];
    heave = it.axis[AX_HEAVE];
    pitch = it.axis[AX_PITCH];
    roll = it.axis[AX_ROLL];
    yaw = it.axis[AX_YAW];
    buttons = it.buttons;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Hold off until every result is in, then let the block settle
  task automatic drain(input int settle);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic run_directed();
    // Reset state and zero rows give zero thrust
    send_item(tick_of());
    drain(QUIET_CYCLES);
    write_reg(CFG_ROW_FIRST + 3'd0, {AXIS_COUNT{8'h7F}});
    write_reg(CFG_ROW_FIRST + 3'd1, {AXIS_COUNT{8'h80}});
    write_reg(CFG_ROW_FIRST + 3'd2, {8'h40, 8'hC0, 8'h40, 8'hC0, 8'h40, 8'hC0});
    write_reg(CFG_ROW_FIRST + 3'd3, {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h40});
    write_reg(CFG_ROW_FIRST + 3'd4, {AXIS_COUNT{8'h01}});
    write_reg(CFG_ROW_LAST, {8'hFF, 8'h7F, 8'h80, 8'h01, 8'h00, 8'h40});
    // Axis extremes, including values outside the percent range
    send_item(command_of(127, 127, 127, 127, 127, 127, 0));
    send_item(tick_of());
    send_item(command_of(-128, -128, -128, -128, -128, -128, 0));
    send_item(tick_of());
    send_item(tick_of());
    // Each button on its own, with a servo button alongside the heave and pitch ones
    send_item(command_of(100, 100, 100, 100, 100, 100, 1 << BTN_HEAVE_UP | 1 << BTN_FRONT_CW));
    send_item(tick_of());
    send_item(command_of(-100, -100, -100, -100, -100, -100,
                         1 << BTN_HEAVE_DOWN | 1 << BTN_FRONT_CCW));
    send_item(tick_of());
    send_item(command_of(0, 0, 0, 0, 0, 0, 1 << BTN_PITCH_UP | 1 << BTN_BACK_CW));
    send_item(tick_of());
    send_item(command_of(0, 0, 0, 0, 0, 0, 1 << BTN_PITCH_DOWN | 1 << BTN_BACK_CCW));
    send_item(tick_of());
    send_item(command_of(50, -50, 25, -25, 10, -10, 1 << BTN_ROLL_CW));
    send_item(command_of(-50, 50, -25, 25, -10, 10, 1 << BTN_ROLL_CCW));
    send_item(tick_of());
    // Both buttons of every pair held cancel to zero
    send_item(command_of(1, -1, 90, -90, 70, 1, 10'h3FF));
    send_item(tick_of());
    send_item(command_of(0, 0, 0, 0, 0, 0, 0));
    send_item(tick_of());
    send_item(tick_of());
  endtask

  // Mostly a command followed by a run of ticks, sometimes loose noise
  task automatic run_random(input int count);
    int sent;
    int ticks;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 4) != 0) begin
        send_item(random_command());
        sent++;
        ticks = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
        for (int k = 0; k < ticks; k++) begin
          send_item(tick_of());
          sent++;
        end
      end else begin
        ticks = $urandom_range(1, 6);
        for (int k = 0; k < ticks; k++) begin
          send_item(($urandom_range(0, 1) == 0) ? random_command() : tick_of());
          sent++;
        end
      end
    end
  endtask

  initial begin
    logic [ACCEL_W-1:0]    accel_val;
    logic [CFG_DATA_W-1:0] accel_word;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    run_directed();

    // Phases with fresh rows and a range of ramp rates
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      drain(QUIET_CYCLES);
      for (int r = 0; r < ROW_COUNT; r++)
        write_reg(CFG_ROW_FIRST + CFG_INDEX_W'(r), random_row(1'($urandom_range(0, 1))));
      case (ph)
        0:       accel_val = '0;
        1:       accel_val = ACCEL_W'(16384);
        2:       accel_val = ACCEL_W'(1);
        3:       accel_val = '1;
        4:       accel_val = ACCEL_W'($urandom_range(16385, 32767));
        5:       accel_val = ACCEL_W'($urandom_range(1, 16384));
        default: accel_val = ACCEL_RESET;
      endcase
      // Upper bits of the word carry junk the register must drop
      accel_word = CFG_DATA_W'({$urandom, $urandom});
      accel_word[ACCEL_W-1:0] = accel_val;
      write_reg(CFG_ACCEL, accel_word);
      if (ph == 2) write_reg(CFG_SPARE, CFG_DATA_W'({$urandom, $urandom}));
      run_random(PHASE_ITEMS / 2);
      // Let everything drain before carrying on
      if (ph == 3) drain(0);
      run_random(PHASE_ITEMS / 2);
    end

    drain(QUIET_CYCLES);
    if (fail_count == 0) begin
      $display("PASS thruster_mixer_with_ramp_unit");
    end else begin
      $display("FAIL thruster_mixer_with_ramp_unit");
    end
    $finish;
  end

endmodule
